// ----- hw/rtl/dwpid_pkg.sv -----
// Shared types, register codes and constants of the dual-wheel speed controller.
package dwpid_pkg;

    // Field widths
    localparam int COUNT_W   = 12;
    localparam int TARGET_W  = 16;
    localparam int DRIVE_W   = 32;
    localparam int SPEED_W   = 20;
    localparam int FFP_W     = 26;
    localparam int ERR_W     = 21;
    localparam int DIFF_W    = 22;
    localparam int IPROD_W   = 31;
    localparam int PPROD_W   = 31;
    localparam int DPROD_W   = 32;
    localparam int INTEG_W   = 24;
    localparam int ISUM_W    = 32;
    localparam int PART_W    = 34;
    localparam int POWER_W   = 35;

    // Stream and register port widths
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 64;
    localparam int ADDR_W     = 5;
    localparam int PDATA_W    = 32;

    // Registered stages from the input register to the result register
    localparam int PIPE_DEPTH = 5;

    // Register map, one 32-bit word per register
    typedef enum logic [2:0] {
        REG_SPEED_SCALE      = 3'd0,
        REG_FEEDFORWARD_GAIN = 3'd1,
        REG_PROPORTIONAL_GAIN = 3'd2,
        REG_INTEGRAL_GAIN    = 3'd3,
        REG_DERIVATIVE_GAIN  = 3'd4,
        REG_INTEGRAL_FLOOR   = 3'd5,
        REG_INTEGRAL_CEILING = 3'd6,
        REG_FULL_SCALE       = 3'd7
    } reg_idx_t;

    // Reset values
    localparam logic [7:0]         SPEED_SCALE_RST = 8'd1;
    localparam logic signed [23:0] FLOOR_RST       = 24'sh800000;
    localparam logic [22:0]        CEILING_RST     = 23'h7FFFFF;
    localparam logic [30:0]        FULL_SCALE_RST  = 31'h7FFFFFFF;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [7:0]         speed_scale;
        logic [9:0]         feedforward_gain;
        logic [9:0]         proportional_gain;
        logic [9:0]         integral_gain;
        logic [9:0]         derivative_gain;
        logic signed [23:0] integral_floor;
        logic [22:0]        integral_ceiling;
        logic [30:0]        full_scale;
    } cfg_t;

    // Stage load strobes, each high when a valid word moves into that stage
    typedef struct packed {
        logic adv_b;
        logic adv_c;
        logic adv_d;
        logic adv_e;
    } ctrl_t;

endpackage

// ----- hw/rtl/dwpid_cfg.sv -----
// Configuration register bank behind the APB-style port.
module dwpid_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dwpid_pkg::ADDR_W-1:0]  paddr,
    input  logic [dwpid_pkg::PDATA_W-1:0] pwdata,
    output logic [dwpid_pkg::PDATA_W-1:0] prdata,
    output logic                          pready,
    output dwpid_pkg::cfg_t               cfg
);

    dwpid_pkg::cfg_t      cfg_reg;
    dwpid_pkg::reg_idx_t  idx;
    logic                 wr_en;

    assign idx    = dwpid_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speed_scale       <= dwpid_pkg::SPEED_SCALE_RST;
            cfg_reg.feedforward_gain  <= '0;
            cfg_reg.proportional_gain <= '0;
            cfg_reg.integral_gain     <= '0;
            cfg_reg.derivative_gain   <= '0;
            cfg_reg.integral_floor    <= dwpid_pkg::FLOOR_RST;
            cfg_reg.integral_ceiling  <= dwpid_pkg::CEILING_RST;
            cfg_reg.full_scale        <= dwpid_pkg::FULL_SCALE_RST;
        end
        else if (wr_en)
        begin
            case (idx)
                dwpid_pkg::REG_SPEED_SCALE:       cfg_reg.speed_scale       <= pwdata[7:0];
                dwpid_pkg::REG_FEEDFORWARD_GAIN:  cfg_reg.feedforward_gain  <= pwdata[9:0];
                dwpid_pkg::REG_PROPORTIONAL_GAIN: cfg_reg.proportional_gain <= pwdata[9:0];
                dwpid_pkg::REG_INTEGRAL_GAIN:     cfg_reg.integral_gain     <= pwdata[9:0];
                dwpid_pkg::REG_DERIVATIVE_GAIN:   cfg_reg.derivative_gain   <= pwdata[9:0];
                dwpid_pkg::REG_INTEGRAL_FLOOR:    cfg_reg.integral_floor    <= $signed(pwdata[23:0]);
                dwpid_pkg::REG_INTEGRAL_CEILING:  cfg_reg.integral_ceiling  <= pwdata[22:0];
                dwpid_pkg::REG_FULL_SCALE:        cfg_reg.full_scale        <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // Read back, floor sign-extended
    always_comb
    begin
        case (idx)
            dwpid_pkg::REG_SPEED_SCALE:       prdata = {24'd0, cfg_reg.speed_scale};
            dwpid_pkg::REG_FEEDFORWARD_GAIN:  prdata = {22'd0, cfg_reg.feedforward_gain};
            dwpid_pkg::REG_PROPORTIONAL_GAIN: prdata = {22'd0, cfg_reg.proportional_gain};
            dwpid_pkg::REG_INTEGRAL_GAIN:     prdata = {22'd0, cfg_reg.integral_gain};
            dwpid_pkg::REG_DERIVATIVE_GAIN:   prdata = {22'd0, cfg_reg.derivative_gain};
            dwpid_pkg::REG_INTEGRAL_FLOOR:    prdata = {{8{cfg_reg.integral_floor[23]}},
                                                        cfg_reg.integral_floor};
            dwpid_pkg::REG_INTEGRAL_CEILING:  prdata = {9'd0, cfg_reg.integral_ceiling};
            dwpid_pkg::REG_FULL_SCALE:        prdata = {1'b0, cfg_reg.full_scale};
            default:                          prdata = '0;
        endcase
    end

endmodule

// ----- hw/rtl/dwpid_wheel.sv -----
// Per-wheel PID datapath: four registered stages plus integral and last-error state.
module dwpid_wheel (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dwpid_pkg::cfg_t                        cfg,
    input  dwpid_pkg::ctrl_t                       ctrl,
    input  logic signed [dwpid_pkg::COUNT_W-1:0]   count,
    input  logic signed [dwpid_pkg::TARGET_W-1:0]  target,
    input  logic                                   zero,
    output logic signed [dwpid_pkg::DRIVE_W-1:0]   drive
);

    // Stage B: speed and feedforward products
    logic signed [dwpid_pkg::SPEED_W-1:0]  speed_b_reg;
    logic signed [dwpid_pkg::FFP_W-1:0]    ffp_b_reg;
    logic signed [dwpid_pkg::TARGET_W-1:0] target_b_reg;
    logic                                  zero_b_reg;
    logic signed [dwpid_pkg::SPEED_W:0]    speed_full;
    logic signed [dwpid_pkg::FFP_W:0]      ffp_full;

    // Stage C: error terms
    logic signed [dwpid_pkg::IPROD_W-1:0]  iprod_c_reg;
    logic signed [dwpid_pkg::PPROD_W-1:0]  pprod_c_reg;
    logic signed [dwpid_pkg::DPROD_W-1:0]  dprod_c_reg;
    logic signed [dwpid_pkg::FFP_W-1:0]    ffp_c_reg;
    logic                                  zero_c_reg;
    logic signed [dwpid_pkg::ERR_W-1:0]    err;
    logic signed [dwpid_pkg::DIFF_W-1:0]   diff;
    logic signed [31:0]                    iprod_full;
    logic signed [31:0]                    pprod_full;
    logic signed [32:0]                    dprod_full;
    logic signed [dwpid_pkg::ERR_W-1:0]    last_err_reg;

    // Stage D: integral update and partial sum
    logic signed [dwpid_pkg::INTEG_W-1:0]  integ_reg;
    logic signed [dwpid_pkg::INTEG_W-1:0]  integ_next;
    logic signed [dwpid_pkg::INTEG_W-1:0]  integ_d_reg;
    logic signed [dwpid_pkg::PART_W-1:0]   part_d_reg;
    logic signed [dwpid_pkg::PART_W-1:0]   part_next;
    logic signed [dwpid_pkg::ISUM_W-1:0]   isum;
    logic                                  zero_d_reg;

    // Stage E: saturated drive
    logic signed [dwpid_pkg::POWER_W-1:0]  power;
    logic signed [dwpid_pkg::POWER_W-1:0]  fs_pos;
    logic signed [dwpid_pkg::DRIVE_W-1:0]  drive_next;
    logic signed [dwpid_pkg::DRIVE_W-1:0]  drive_reg;

    // Speed and feedforward multiplies
    assign speed_full = $signed({1'b0, cfg.speed_scale}) * count;
    assign ffp_full   = $signed({1'b0, cfg.feedforward_gain}) * target;

    always_ff @(posedge clk)
    begin
        if (ctrl.adv_b)
        begin
            speed_b_reg  <= speed_full[dwpid_pkg::SPEED_W-1:0];
            ffp_b_reg    <= ffp_full[dwpid_pkg::FFP_W-1:0];
            target_b_reg <= target;
            zero_b_reg   <= zero;
        end
    end

    // Error, change of error and gain products
    assign err        = dwpid_pkg::ERR_W'(target_b_reg) - dwpid_pkg::ERR_W'(speed_b_reg);
    assign diff       = dwpid_pkg::DIFF_W'(err) - dwpid_pkg::DIFF_W'(last_err_reg);
    assign iprod_full = $signed({1'b0, cfg.integral_gain}) * err;
    assign pprod_full = $signed({1'b0, cfg.proportional_gain}) * err;
    assign dprod_full = $signed({1'b0, cfg.derivative_gain}) * diff;

    always_ff @(posedge clk)
    begin
        if (ctrl.adv_c)
        begin
            iprod_c_reg <= iprod_full[dwpid_pkg::IPROD_W-1:0];
            pprod_c_reg <= pprod_full[dwpid_pkg::PPROD_W-1:0];
            dprod_c_reg <= dprod_full[dwpid_pkg::DPROD_W-1:0];
            ffp_c_reg   <= ffp_b_reg;
            zero_c_reg  <= zero_b_reg;
        end
    end

    // Keep the last error unless both targets were zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_err_reg <= '0;
        else if (ctrl.adv_c && !zero_b_reg)
            last_err_reg <= err;
    end

    // Clamp the integral, or clear it when both targets are zero; the floor test wins
    assign isum = dwpid_pkg::ISUM_W'(integ_reg) + dwpid_pkg::ISUM_W'(iprod_c_reg);

    always_comb
    begin
        if (zero_c_reg)
            integ_next = '0;
        else if (isum < dwpid_pkg::ISUM_W'(cfg.integral_floor))
            integ_next = cfg.integral_floor;
        else if (isum > $signed({9'd0, cfg.integral_ceiling}))
            integ_next = $signed({1'b0, cfg.integral_ceiling});
        else
            integ_next = isum[dwpid_pkg::INTEG_W-1:0];
    end

    assign part_next = dwpid_pkg::PART_W'(ffp_c_reg) + dwpid_pkg::PART_W'(pprod_c_reg)
                     + dwpid_pkg::PART_W'(dprod_c_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            integ_reg <= '0;
        else if (ctrl.adv_d)
            integ_reg <= integ_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv_d)
        begin
            integ_d_reg <= integ_next;
            part_d_reg  <= part_next;
            zero_d_reg  <= zero_c_reg;
        end
    end

    // Sum and saturate to plus or minus full scale; drive zero when both targets are zero
    assign power  = dwpid_pkg::POWER_W'(part_d_reg) + dwpid_pkg::POWER_W'(integ_d_reg);
    assign fs_pos = $signed({4'd0, cfg.full_scale});

    always_comb
    begin
        if (zero_d_reg)
            drive_next = '0;
        else if (power > fs_pos)
            drive_next = $signed({1'b0, cfg.full_scale});
        else if (power < -fs_pos)
            drive_next = -$signed({1'b0, cfg.full_scale});
        else
            drive_next = power[dwpid_pkg::DRIVE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv_e)
            drive_reg <= drive_next;
    end

    assign drive = drive_reg;

endmodule

// ----- hw/rtl/dual_wheel_pid_speed_controller.sv -----
// Top level of the dual-wheel PID speed controller: input register, stage control, wheels.
//
//  Channel   Direction  Word
//  s_axis    in         tdata[55:0] = left_count, right_count, left_target, right_target
//  m_axis    out        tdata[63:0] = left_motor, right_motor
//  APB       in/out     eight 32-bit registers at byte address 4*index
//
//  One word is taken per cycle while s_axis_tready is high; a result passes the
//  input register plus four datapath stages (speed and feedforward multiplies,
//  error and gain products, integral clamp and partial sum, final sum and saturation).
//  Integral and last-error state close their loops within a single stage.
//  Each stage holds while the stage after it is full and stalled, so m_axis_tready
//  low fills the pipe up to five words before s_axis_tready drops.
//  rst_n clears valid bits, configuration registers and controller state at once.
module dual_wheel_pid_speed_controller (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // left_count[11:0], right_count[23:12], left_target[39:24], right_target[55:40]
    input  logic [dwpid_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // left_motor[31:0], right_motor[63:32]
    output logic [dwpid_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dwpid_pkg::ADDR_W-1:0]       paddr,
    input  logic [dwpid_pkg::PDATA_W-1:0]      pwdata,
    output logic [dwpid_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);

    dwpid_pkg::cfg_t   cfg;
    dwpid_pkg::ctrl_t  ctrl;

    logic a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg;
    logic ready_a, ready_b, ready_c, ready_d, ready_e;

    logic signed [dwpid_pkg::COUNT_W-1:0]  lcount_reg, rcount_reg;
    logic signed [dwpid_pkg::TARGET_W-1:0] ltarget_reg, rtarget_reg;
    logic                                  zero_a;
    logic signed [dwpid_pkg::DRIVE_W-1:0]  left_motor, right_motor;

    dwpid_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // A stage loads when it is empty or the stage after it moves on
    assign ready_e = !e_v_reg || m_axis_tready;
    assign ready_d = !d_v_reg || ready_e;
    assign ready_c = !c_v_reg || ready_d;
    assign ready_b = !b_v_reg || ready_c;
    assign ready_a = !a_v_reg || ready_b;

    assign ctrl.adv_b = ready_b && a_v_reg;
    assign ctrl.adv_c = ready_c && b_v_reg;
    assign ctrl.adv_d = ready_d && c_v_reg;
    assign ctrl.adv_e = ready_e && d_v_reg;

    assign s_axis_tready = ready_a;
    assign m_axis_tvalid = e_v_reg;

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else
        begin
            if (ready_a)
                a_v_reg <= s_axis_tvalid;
            if (ready_b)
                b_v_reg <= a_v_reg;
            if (ready_c)
                c_v_reg <= b_v_reg;
            if (ready_d)
                d_v_reg <= c_v_reg;
            if (ready_e)
                e_v_reg <= d_v_reg;
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (ready_a && s_axis_tvalid)
        begin
            lcount_reg  <= $signed(s_axis_tdata[11:0]);
            rcount_reg  <= $signed(s_axis_tdata[23:12]);
            ltarget_reg <= $signed(s_axis_tdata[39:24]);
            rtarget_reg <= $signed(s_axis_tdata[55:40]);
        end
    end

    // Both targets zero: clear integrals, drive zero
    assign zero_a = (ltarget_reg == '0) && (rtarget_reg == '0);

    dwpid_wheel u_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .ctrl   (ctrl),
        .count  (lcount_reg),
        .target (ltarget_reg),
        .zero   (zero_a),
        .drive  (left_motor)
    );

    dwpid_wheel u_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .ctrl   (ctrl),
        .count  (rcount_reg),
        .target (rtarget_reg),
        .zero   (zero_a),
        .drive  (right_motor)
    );

    assign m_axis_tdata = {right_motor, left_motor};

endmodule

// ----- hw/rtl/dwpid_checker.sv -----
// Port-level checker for the dual-wheel PID speed controller, bound to the top level.
module dwpid_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [dwpid_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [dwpid_pkg::ADDR_W-1:0]       paddr,
    input  logic [dwpid_pkg::PDATA_W-1:0]      pwdata,
    input  logic [dwpid_pkg::PDATA_W-1:0]      prdata,
    input  logic                               pready
);

    logic [30:0] fs_reg;
    logic [2:0]  pending_reg;
    logic        s_acc, m_acc;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = m_axis_tvalid && m_axis_tready;

    // Track full scale from register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fs_reg <= dwpid_pkg::FULL_SCALE_RST;
        else if (psel && penable && pwrite && pready
                 && paddr[4:2] == dwpid_pkg::REG_FULL_SCALE)
            fs_reg <= pwdata[30:0];
    end

    // Count words in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else if (s_acc && !m_acc)
            pending_reg <= pending_reg + 3'd1;
        else if (m_acc && !s_acc)
            pending_reg <= pending_reg - 3'd1;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != 3'd0)
        else $error("result word without an input word");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'(dwpid_pkg::PIPE_DEPTH))
        else $error("more words in flight than pipeline stages");

    a_drive_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            $signed(m_axis_tdata[31:0])  <= $signed({1'b0, fs_reg}) &&
            $signed(m_axis_tdata[31:0])  >= -$signed({1'b0, fs_reg}) &&
            $signed(m_axis_tdata[63:32]) <= $signed({1'b0, fs_reg}) &&
            $signed(m_axis_tdata[63:32]) >= -$signed({1'b0, fs_reg}))
        else $error("drive beyond full scale");

    a_fs_readback: assert property (@(posedge clk) disable iff (!rst_n)
        paddr[4:2] == dwpid_pkg::REG_FULL_SCALE |-> prdata == {1'b0, fs_reg})
        else $error("full scale read back wrong");

endmodule

bind dual_wheel_pid_speed_controller dwpid_checker u_dwpid_checker (.*);
